>>> rtl/wsts_pkg.sv
// ----------------------------------------------------------------------------
// wsts_pkg - shared types and constants of the weighted sum-tree sampler
// Field widths, command and status codes, controller states, the command and
// status structs between controller and datapath, and elaboration helpers.
// ----------------------------------------------------------------------------
package wsts_pkg;

	// default tree shape
	localparam int BRANCHING_DEF = 4;
	localparam int LEVELS_DEF    = 3;

	// field widths
	localparam int W_W   = 32;  // leaf weight, unsigned Q16.16
	localparam int SUM_W = 38;  // node sums and draw
	localparam int IDX_W = 6;   // reported leaf index
	localparam int ST_W  = 2;   // status code

	// command codes
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_SELECT = 1'b1;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP_RD,
		S_APP_WR,
		S_SEL_RD,
		S_SEL_CMP,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch accepted word, reset walk
		logic app_step;  // append: read next node on the path, descend
		logic app_wr;    // append: write updated node sum
		logic leaf_wr;   // append: store leaf, bump count and root
		logic sel_cmp;   // select: compare draw with child sum
		logic res_load;  // move result into output register
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic last_lvl;
		logic last_child;
		logic hit;
	} sts_t;

	function automatic int ipow(input int b, input int e);
		int r;
		r = 1;
		for (int i = 0; i < e; i++) begin
			r = r * b;
		end
		return r;
	endfunction

	// address width for a store of n entries, at least one bit
	function automatic int aw(input int n);
		int r;
		r = (n > 1) ? $clog2(n) : 1;
		return r;
	endfunction

endpackage

>>> rtl/wsts_ram.sv
// ----------------------------------------------------------------------------
// wsts_ram - generic simple dual-port RAM
// One write port, one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module wsts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/wsts_ctrl.sv
// ----------------------------------------------------------------------------
// wsts_ctrl - sequencing controller of the sum-tree sampler
// Walks one command word at a time through append or select steps and owns
// the output-register handshake.
// ----------------------------------------------------------------------------
module wsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  logic            command,
	output logic            res_valid,
	input  logic            res_ready,
	input  wsts_pkg::sts_t  sts,
	output wsts_pkg::ctl_t  ctl
);
	import wsts_pkg::*;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   res_free;

	assign res_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					if (command == CMD_SELECT) begin
						state_d = S_SEL_RD;
					end else if (sts.full) begin
						state_d = S_FIN;
					end else begin
						state_d = S_APP_RD;
					end
				end
			end
			S_APP_RD: begin
				if (sts.last_lvl) begin
					ctl.leaf_wr = 1'b1;
					state_d     = S_FIN;
				end else begin
					ctl.app_step = 1'b1;
					state_d      = S_APP_WR;
				end
			end
			S_APP_WR: begin
				ctl.app_wr = 1'b1;
				state_d    = S_APP_RD;
			end
			S_SEL_RD: begin
				state_d = S_SEL_CMP;
			end
			S_SEL_CMP: begin
				ctl.sel_cmp = 1'b1;
				if (sts.hit) begin
					state_d = sts.last_lvl ? S_FIN : S_SEL_RD;
				end else begin
					state_d = sts.last_child ? S_FIN : S_SEL_RD;
				end
			end
			S_FIN: begin
				if (res_free) begin
					ctl.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |=> res_valid_q)
		else $error("result not presented after load");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && !res_free |=> (state_q == S_FIN))
		else $error("left finish while output register busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> (state_q != S_IDLE))
		else $error("accepted word did not start work");

endmodule

>>> rtl/wsts_dp.sv
// ----------------------------------------------------------------------------
// wsts_dp - datapath of the sum-tree sampler
// Leaf weight RAM, node sum RAM, root total, leaf count with base-B digits,
// walk registers and the output register.
// ----------------------------------------------------------------------------
module wsts_dp #(
	parameter int BRANCHING = wsts_pkg::BRANCHING_DEF,
	parameter int LEVELS    = wsts_pkg::LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       command,
	input  logic [wsts_pkg::W_W-1:0]   weight,
	input  logic [wsts_pkg::SUM_W-1:0] draw,
	input  wsts_pkg::ctl_t             ctl,
	output wsts_pkg::sts_t             sts,
	output logic [wsts_pkg::IDX_W-1:0] leaf_index,
	output logic [wsts_pkg::ST_W-1:0]  status,
	output logic                       full_res,
	output logic [wsts_pkg::SUM_W-1:0] total
);
	import wsts_pkg::*;

	localparam int LEAF_CAP = ipow(BRANCHING, LEVELS);
	localparam int NODE_CAP = (LEAF_CAP - 1) / (BRANCHING - 1);
	localparam int CNT_W    = $clog2(LEAF_CAP + 1);
	localparam int LEAF_AW  = aw(LEAF_CAP);
	localparam int NODE_AW  = aw(NODE_CAP);
	localparam int CH_W     = $clog2(BRANCHING);
	localparam int DEP_W    = aw(LEVELS);
	localparam int NXW      = NODE_AW + CH_W + 2;

	// walk state
	logic             cmd_q;
	logic [W_W-1:0]   w_q;
	logic [SUM_W-1:0] r_q;
	logic [DEP_W-1:0] depth_q;
	logic [CH_W-1:0]  child_q;
	logic [NODE_AW-1:0] node_q;
	logic [CNT_W-1:0] cbase_q;   // first leaf under the current child

	// tree bookkeeping
	logic [SUM_W-1:0] total_q;
	logic [CNT_W-1:0] count_q;
	logic [CH_W-1:0]  digit_q [LEVELS];

	// pending result
	logic [CNT_W-1:0] res_idx_q;
	logic [ST_W-1:0]  res_st_q;

	// output register
	logic [IDX_W-1:0] leaf_index_q;
	logic [ST_W-1:0]  status_q;
	logic             full_res_q;
	logic [SUM_W-1:0] total_out_q;

	logic               full;
	logic               last_lvl;
	logic               last_child;
	logic [CH_W-1:0]    dsel;
	logic               fresh;
	logic [CNT_W-1:0]   span;
	logic [NXW-1:0]     nxt_full;
	logic [NXW-1:0]     selc_full;
	logic [NODE_AW-1:0] node_raddr;
	logic [SUM_W-1:0]   node_rd;
	logic [W_W-1:0]     leaf_rd;
	logic [SUM_W-1:0]   node_wdata;
	logic [SUM_W-1:0]   s;
	logic               hit;
	logic [CNT_W+IDX_W-1:0] idx_ext;

	assign full       = (count_q == CNT_W'(LEAF_CAP));
	assign last_lvl   = (depth_q == DEP_W'(LEVELS - 1));
	assign last_child = (child_q == CH_W'(BRANCHING - 1));

	// path digit at this depth, node freshness, child span
	always_comb begin
		dsel  = '0;
		fresh = 1'b1;
		span  = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (depth_q == DEP_W'(i)) begin
				dsel = digit_q[i];
				span = CNT_W'(ipow(BRANCHING, LEVELS - 1 - i));
			end
			if ((DEP_W'(i) >= depth_q) && (digit_q[i] != '0)) begin
				fresh = 1'b0;
			end
		end
	end

	assign nxt_full  = NXW'(node_q) * NXW'(BRANCHING) + NXW'(1) + NXW'(dsel);
	assign selc_full = NXW'(node_q) * NXW'(BRANCHING) + NXW'(1) + NXW'(child_q);
	assign node_raddr = (cmd_q == CMD_APPEND) ? nxt_full[NODE_AW-1:0]
	                                          : selc_full[NODE_AW-1:0];

	// a node first touched by this append starts from zero
	assign node_wdata = (fresh ? '0 : node_rd) + SUM_W'(w_q);

	// children at or beyond the fill count hold no weight yet
	always_comb begin
		if (cbase_q >= count_q) begin
			s = '0;
		end else if (last_lvl) begin
			s = SUM_W'(leaf_rd);
		end else begin
			s = node_rd;
		end
	end
	assign hit = r_q < s;

	wsts_ram #(
		.WIDTH (W_W),
		.DEPTH (LEAF_CAP),
		.AW    (LEAF_AW)
	) u_leaf_ram (
		.clk   (clk),
		.we    (ctl.leaf_wr),
		.waddr (count_q[LEAF_AW-1:0]),
		.wdata (w_q),
		.raddr (cbase_q[LEAF_AW-1:0]),
		.rdata (leaf_rd)
	);

	wsts_ram #(
		.WIDTH (SUM_W),
		.DEPTH (NODE_CAP),
		.AW    (NODE_AW)
	) u_node_ram (
		.clk   (clk),
		.we    (ctl.app_wr),
		.waddr (node_q),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rd)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				digit_q[i] <= '0;
			end
		end else if (ctl.leaf_wr) begin
			total_q <= total_q + SUM_W'(w_q);
			count_q <= count_q + CNT_W'(1);
			// base-B increment, least significant digit is the deepest
			begin
				logic carry;
				carry = 1'b1;
				for (int j = LEVELS - 1; j >= 0; j--) begin
					if (carry) begin
						if (digit_q[j] == CH_W'(BRANCHING - 1)) begin
							digit_q[j] <= '0;
						end else begin
							digit_q[j] <= digit_q[j] + CH_W'(1);
							carry = 1'b0;
						end
					end
				end
			end
		end
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= command;
			w_q     <= weight;
			r_q     <= draw;
			depth_q <= '0;
			child_q <= '0;
			node_q  <= '0;
			cbase_q <= '0;
			if ((command == CMD_APPEND) && full) begin
				res_idx_q <= '0;
				res_st_q  <= ST_OVERFLOW;
			end
		end
		if (ctl.app_step) begin
			node_q  <= nxt_full[NODE_AW-1:0];
			depth_q <= depth_q + DEP_W'(1);
		end
		if (ctl.leaf_wr) begin
			res_idx_q <= count_q;
			res_st_q  <= ST_OK;
		end
		if (ctl.sel_cmp) begin
			if (hit) begin
				if (last_lvl) begin
					res_idx_q <= cbase_q;
					res_st_q  <= ST_OK;
				end else begin
					node_q  <= selc_full[NODE_AW-1:0];
					depth_q <= depth_q + DEP_W'(1);
					child_q <= '0;
				end
			end else begin
				r_q     <= r_q - s;
				cbase_q <= cbase_q + span;
				child_q <= child_q + CH_W'(1);
				if (last_child) begin
					res_idx_q <= '0;
					res_st_q  <= ST_NOT_FOUND;
				end
			end
		end
	end

	assign idx_ext = (CNT_W + IDX_W)'(res_idx_q);

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			leaf_index_q <= idx_ext[IDX_W-1:0];
			status_q     <= res_st_q;
			full_res_q   <= full;
			total_out_q  <= total_q;
		end
	end

	assign sts.full       = full;
	assign sts.last_lvl   = last_lvl;
	assign sts.last_child = last_child;
	assign sts.hit        = hit;

	assign leaf_index = leaf_index_q;
	assign status     = status_q;
	assign full_res   = full_res_q;
	assign total      = total_out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LEAF_CAP))
		else $error("leaf count beyond capacity");

	a_no_store_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.leaf_wr |-> !full)
		else $error("leaf stored into a full tree");

	a_hit_inside_fill: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sel_cmp && hit |-> (cbase_q < count_q))
		else $error("select hit an unfilled child");

endmodule

>>> rtl/weighted_sum_tree_sampler_unit.sv
// ----------------------------------------------------------------------------
// weighted_sum_tree_sampler_unit - k-ary sum tree for weighted event choice
// Top level: command word in, one result word out per command.
// ----------------------------------------------------------------------------
// Keeps up to BRANCHING**LEVELS leaf weights (unsigned Q16.16) and the partial
// sums of a complete BRANCHING-ary tree over them. An append (command 0)
// stores the next leaf and adds its weight to every sum on its path; a full
// tree answers status 2 and changes nothing. A select (command 1) walks from
// the root, subtracting child sums from the draw until the draw falls below a
// child, and returns that leaf; a draw not below the total answers status 1.
// Every result carries the full flag and root total after the command. Words
// are handled one at a time, and the next word is taken the cycle after the
// result is registered. The pace is set by the node-sum RAM: one read port
// with registered data, so each child on a select takes a read and a
// compare, and each node below the root on an append a read and a write,
// plus a last step to store the leaf and bump the root total. The output
// register frees the input side while a result waits. Both RAMs start
// undefined; nothing needs clearing after reset because a node or leaf
// whose first leaf lies at or beyond the fill count is read as zero and a
// node is written from zero on its first append.
// ----------------------------------------------------------------------------
module weighted_sum_tree_sampler_unit #(
	parameter int BRANCHING = wsts_pkg::BRANCHING_DEF,
	parameter int LEVELS    = wsts_pkg::LEVELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// command channel
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic                       command,
	input  logic [wsts_pkg::W_W-1:0]   weight,
	input  logic [wsts_pkg::SUM_W-1:0] draw,
	// result channel
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [wsts_pkg::IDX_W-1:0] leaf_index,
	output logic [wsts_pkg::ST_W-1:0]  status,
	output logic                       full_res,
	output logic [wsts_pkg::SUM_W-1:0] total
);
	import wsts_pkg::*;

	ctl_t ctl;  // step commands, controller to datapath
	sts_t sts;  // walk status, datapath to controller

	// sequencer: one word in flight, result handshake
	wsts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.command   (command),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// storage, sums, walk registers and output register
	wsts_dp #(
		.BRANCHING (BRANCHING),
		.LEVELS    (LEVELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.weight     (weight),
		.draw       (draw),
		.ctl        (ctl),
		.sts        (sts),
		.leaf_index (leaf_index),
		.status     (status),
		.full_res   (full_res),
		.total      (total)
	);

endmodule
